FILE: rtl/cyclic_node_dll_state_machine_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cyclic node DLL state machine
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CYCLIC_NODE_DLL_STATE_MACHINE_UNIT_DEFINES_SVH
`define CYCLIC_NODE_DLL_STATE_MACHINE_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define CNDSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define CNDSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cndsm_pkg.sv
// ----------------------------------------------------------------------------
// cndsm_pkg
// Types and codes shared by the controlled-node DLL state machine modules.
// ----------------------------------------------------------------------------
package cndsm_pkg;

    // DLL states
    typedef enum logic [1:0] {
        ST_INIT      = 2'd0,
        ST_WAIT_PREQ = 2'd1,
        ST_WAIT_SOC  = 2'd2,
        ST_WAIT_SOA  = 2'd3
    } dll_state_t;

    // Event kinds
    typedef enum logic [2:0] {
        EV_SOC     = 3'd0,
        EV_PREQ    = 3'd1,
        EV_PRES    = 3'd2,
        EV_SOA     = 3'd3,
        EV_ASND    = 3'd4,
        EV_TIMEOUT = 3'd5,
        EV_AINV    = 3'd6,
        EV_OTHER   = 3'd7
    } ev_kind_t;

    // Management-state classes
    localparam logic [2:0] CLS_OFF         = 3'd0;
    localparam logic [2:0] CLS_PREOP1      = 3'd1;
    localparam logic [2:0] CLS_PREOP2      = 3'd2;
    localparam logic [2:0] CLS_READY       = 3'd3;
    localparam logic [2:0] CLS_OPERATIONAL = 3'd4;
    localparam logic [2:0] CLS_STOPPED     = 3'd5;
    localparam logic [2:0] CLS_OTHER       = 3'd6;
    localparam logic [2:0] CLS_RESERVED    = 3'd7;

    // State carried from one event to the next
    typedef struct packed {
        dll_state_t dll_state;
        logic       loss_reported;
        logic       timeout_seen;
    } node_state_t;

    // Flags produced by one event
    typedef struct packed {
        logic loss_soc;
        logic loss_soa;
        logic loss_preq;
        logic preq_received;
        logic error_post;
    } flags_t;

endpackage

FILE: rtl/cndsm_next_state.sv
// ----------------------------------------------------------------------------
// cndsm_next_state
// Next-state and flag decode for one event against the current node state.
// ----------------------------------------------------------------------------
module cndsm_next_state
    import cndsm_pkg::*;
(
    input  logic [2:0]  kind,
    input  logic [2:0]  nmt_class,
    input  logic        mux_cycle_zero,
    input  logic        async_invite_enabled,
    input  node_state_t cur,
    output node_state_t nxt,
    output flags_t      flags
);

    ev_kind_t ev;
    logic     ready;
    logic     preop2;
    logic     soc;
    logic     soa;
    logic     preq;
    logic     rpreq;

    // Fold a disabled AInv into the catch-all event
    always_comb
    begin
        ev = ev_kind_t'(kind);
        if (ev == EV_AINV && !async_invite_enabled)
        begin
            ev = EV_OTHER;
        end
    end

    assign ready  = (nmt_class == CLS_READY || nmt_class == CLS_OPERATIONAL) && mux_cycle_zero;
    assign preop2 = (nmt_class == CLS_PREOP2);

    // Decode transition and loss reports
    always_comb
    begin
        logic lr;
        logic ts;
        logic fire_soc;
        logic fire_tmo;

        // once-per-cycle report helpers on the current flags
        lr       = cur.loss_reported;
        ts       = cur.timeout_seen;
        fire_soc = !lr;
        fire_tmo = !lr || ts;

        nxt   = cur;
        soc   = 1'b0;
        soa   = 1'b0;
        preq  = 1'b0;
        rpreq = 1'b0;

        case (nmt_class)
            CLS_OFF:
            begin
                nxt.dll_state = ST_INIT;
            end
            CLS_PREOP1:
            begin
                nxt.dll_state = (ev == EV_SOC) ? ST_WAIT_PREQ : ST_INIT;
            end
            CLS_PREOP2, CLS_READY, CLS_OPERATIONAL:
            begin
                case (cur.dll_state)
                    ST_INIT:
                    begin
                        nxt.dll_state = ST_WAIT_PREQ;
                    end
                    ST_WAIT_PREQ:
                    begin
                        case (ev)
                            EV_PREQ:
                            begin
                                rpreq         = 1'b1;
                                nxt.dll_state = ST_WAIT_SOA;
                            end
                            EV_TIMEOUT:
                            begin
                                if (!preop2)
                                begin
                                    soc               = fire_tmo;
                                    nxt.loss_reported = 1'b1;
                                    nxt.timeout_seen  = 1'b1;
                                    soa               = 1'b1;
                                    nxt.dll_state     = ST_WAIT_SOC;
                                end
                            end
                            EV_AINV:
                            begin
                                preq          = ready;
                                soa           = ready;
                                nxt.dll_state = ST_WAIT_SOC;
                            end
                            EV_SOA:
                            begin
                                preq          = ready;
                                nxt.dll_state = ST_WAIT_SOC;
                            end
                            EV_SOC, EV_ASND:
                            begin
                                soa = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    ST_WAIT_SOC:
                    begin
                        case (ev)
                            EV_SOC:
                            begin
                                nxt.dll_state     = ST_WAIT_PREQ;
                                nxt.loss_reported = 1'b0;
                                nxt.timeout_seen  = 1'b0;
                            end
                            EV_TIMEOUT:
                            begin
                                if (!preop2)
                                begin
                                    soc               = fire_tmo;
                                    nxt.loss_reported = 1'b1;
                                    nxt.timeout_seen  = 1'b1;
                                end
                            end
                            EV_PRES, EV_PREQ:
                            begin
                                nxt.dll_state     = ST_WAIT_SOA;
                                soc               = fire_soc;
                                nxt.loss_reported = 1'b1;
                            end
                            EV_SOA:
                            begin
                                if (preop2)
                                begin
                                    soc = 1'b1;
                                end
                                else
                                begin
                                    soc               = fire_soc;
                                    nxt.loss_reported = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    default:
                    begin
                        // wait SoA
                        case (ev)
                            EV_TIMEOUT:
                            begin
                                if (!preop2)
                                begin
                                    soc               = fire_tmo;
                                    nxt.loss_reported = 1'b1;
                                    nxt.timeout_seen  = 1'b1;
                                    nxt.dll_state     = ST_WAIT_SOC;
                                end
                            end
                            EV_PREQ:
                            begin
                                // report against old flags, then clear for the new cycle
                                soc               = fire_soc;
                                soa               = 1'b1;
                                nxt.dll_state     = ST_WAIT_SOC;
                                nxt.loss_reported = 1'b0;
                                nxt.timeout_seen  = 1'b0;
                            end
                            EV_SOA:
                            begin
                                nxt.dll_state     = ST_WAIT_SOC;
                                nxt.loss_reported = 1'b0;
                                nxt.timeout_seen  = 1'b0;
                            end
                            EV_SOC:
                            begin
                                soa           = 1'b1;
                                nxt.dll_state = ST_WAIT_PREQ;
                            end
                            EV_ASND:
                            begin
                                soa = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                endcase
            end
            CLS_STOPPED:
            begin
                case (cur.dll_state)
                    ST_INIT:
                    begin
                        nxt.dll_state = ST_WAIT_SOA;
                    end
                    ST_WAIT_PREQ:
                    begin
                        case (ev)
                            EV_PREQ:
                            begin
                                nxt.dll_state = ST_WAIT_SOA;
                            end
                            EV_TIMEOUT:
                            begin
                                soc               = fire_tmo;
                                nxt.loss_reported = 1'b1;
                                nxt.timeout_seen  = 1'b1;
                                soa               = 1'b1;
                                nxt.dll_state     = ST_WAIT_SOC;
                            end
                            EV_SOA:
                            begin
                                nxt.dll_state = ST_WAIT_SOC;
                            end
                            EV_SOC, EV_ASND:
                            begin
                                soa = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    ST_WAIT_SOC:
                    begin
                        case (ev)
                            EV_SOC:
                            begin
                                nxt.dll_state = ST_WAIT_SOA;
                            end
                            EV_PREQ, EV_SOA:
                            begin
                                soc               = fire_soc;
                                nxt.loss_reported = 1'b1;
                            end
                            EV_TIMEOUT:
                            begin
                                soc               = fire_tmo;
                                nxt.loss_reported = 1'b1;
                                nxt.timeout_seen  = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    default:
                    begin
                        // wait SoA
                        case (ev)
                            EV_TIMEOUT:
                            begin
                                soc               = fire_tmo;
                                nxt.loss_reported = 1'b1;
                                nxt.timeout_seen  = 1'b1;
                                soa               = 1'b1;
                                nxt.dll_state     = ST_WAIT_SOC;
                            end
                            EV_AINV:
                            begin
                                soa           = 1'b1;
                                nxt.dll_state = ST_WAIT_SOC;
                            end
                            EV_SOA:
                            begin
                                nxt.dll_state = ST_WAIT_SOC;
                            end
                            EV_SOC, EV_ASND:
                            begin
                                soa = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                endcase
            end
            default:
            begin
                // unknown class: hold everything
            end
        endcase
    end

    // Pack the flags
    always_comb
    begin
        flags.loss_soc      = soc;
        flags.loss_soa      = soa;
        flags.loss_preq     = preq;
        flags.preq_received = rpreq;
        flags.error_post    = soc | soa | preq | rpreq;
    end

endmodule

FILE: rtl/cyclic_node_dll_state_machine_unit.sv
// ----------------------------------------------------------------------------
// cyclic_node_dll_state_machine_unit
// Controlled-node DLL state machine with registered event and result beats.
// ----------------------------------------------------------------------------
// One event beat is taken per clock while evt_stall is low: the event is
// captured in an input register at the accepting edge, decoded against the
// DLL state and loss-report flags, and written with the new state into the
// result register once that register is free or draining, which raises
// res_valid. The state registers update in the same edge that loads the
// result, so back-to-back events chain without bubbles; the input register
// lets one more event in while a result beat is held by res_stall. cfg_wr_en
// writes async_invite_enabled into a register.
module cyclic_node_dll_state_machine_unit
    import cndsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,

    input  logic       evt_valid,
    output logic       evt_stall,
    input  logic [2:0] kind,
    input  logic [2:0] nmt_class,
    input  logic       mux_cycle_zero,

    output logic       res_valid,
    input  logic       res_stall,
    output logic [1:0] dll_state_out,
    output logic       loss_soc,
    output logic       loss_soa,
    output logic       loss_preq,
    output logic       preq_received,
    output logic       error_post
);

`include "cyclic_node_dll_state_machine_unit_defines.svh"

    logic        ainv_en_reg;
    logic        in_vld_reg;
    logic [2:0]  kind_reg;
    logic [2:0]  cls_reg;
    logic        mux0_reg;
    node_state_t state_reg;
    node_state_t state_next;
    flags_t      flags_next;
    logic        res_vld_reg;
    logic [1:0]  res_state_reg;
    flags_t      res_flags_reg;
    logic        advance;
    logic        evt_take;

    // Move the input beat forward when the result register is free or draining
    assign advance   = in_vld_reg && (!res_vld_reg || !res_stall);
    assign evt_stall = in_vld_reg && !advance;
    assign evt_take  = evt_valid && !evt_stall;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ainv_en_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            ainv_en_reg <= cfg_wr_data;
        end
    end

    // Capture the event beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (evt_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            kind_reg <= kind;
            cls_reg  <= nmt_class;
            mux0_reg <= mux_cycle_zero;
        end
    end

    // Decode the held event
    cndsm_next_state u_next_state (
        .kind                 (kind_reg),
        .nmt_class            (cls_reg),
        .mux_cycle_zero       (mux0_reg),
        .async_invite_enabled (ainv_en_reg),
        .cur                  (state_reg),
        .nxt                  (state_next),
        .flags                (flags_next)
    );

    // Advance node state with the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '{dll_state: ST_INIT, loss_reported: 1'b0, timeout_seen: 1'b0};
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg   <= state_next;
                res_vld_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_state_reg <= state_next.dll_state;
            res_flags_reg <= flags_next;
        end
    end

    assign res_valid     = res_vld_reg;
    assign dll_state_out = res_state_reg;
    assign loss_soc      = res_flags_reg.loss_soc;
    assign loss_soa      = res_flags_reg.loss_soa;
    assign loss_preq     = res_flags_reg.loss_preq;
    assign preq_received = res_flags_reg.preq_received;
    assign error_post    = res_flags_reg.error_post;

    // Checks
    `CNDSM_ASSERT_SAME(a_err_post_or, res_valid, error_post == (loss_soc | loss_soa | loss_preq | preq_received), "error_post differs from the OR of the flags")
    `CNDSM_ASSERT_SAME(a_preq_to_soa, res_valid && preq_received, dll_state_out == ST_WAIT_SOA, "poll request accepted without moving to wait SoA")
    `CNDSM_ASSERT_SAME(a_stall_full, evt_stall, in_vld_reg && res_vld_reg && res_stall, "event stalled with room in the pipeline")
    `CNDSM_ASSERT_NEXT(a_unknown_hold, advance && (cls_reg == CLS_OTHER || cls_reg == CLS_RESERVED), state_reg == $past(state_reg) && !error_post, "unknown class changed state or raised a flag")
    `CNDSM_ASSERT_NEXT(a_soc_marks, advance && flags_next.loss_soc, state_reg.loss_reported || state_reg.dll_state == ST_WAIT_SOC, "SoC loss reported without marking the cycle")

endmodule

FILE: tb/cyclic_node_dll_state_machine_unit_checker.sv
// ----------------------------------------------------------------------------
// DLL state machine result checker
// Watches the event, result and configuration ports of the controlled-node
// DLL state machine, predicts every result beat from the accepted event beats
// and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cyclic_node_dll_state_machine_unit_checker
    import cndsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,

    input  logic       evt_valid,
    input  logic       evt_stall,
    input  logic [2:0] kind,
    input  logic [2:0] nmt_class,
    input  logic       mux_cycle_zero,

    input  logic       res_valid,
    input  logic       res_stall,
    input  logic [1:0] dll_state_out,
    input  logic       loss_soc,
    input  logic       loss_soa,
    input  logic       loss_preq,
    input  logic       preq_received,
    input  logic       error_post,

    output int         fail_count,
    output int         pending_count
);

    typedef struct packed {
        dll_state_t dll_state;
        flags_t     flags;
    } dll_result_t;

    // Shadow of the node state and the invite enable
    dll_state_t  node_state;
    logic        soc_loss_flagged;
    logic        soc_timeout_flagged;
    logic        invite_enable;

    dll_result_t pending_outcomes[$];

    // Report SoC loss once per cycle
    function automatic logic report_soc_loss();
        if (!soc_loss_flagged) begin
            soc_loss_flagged = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Report SoC loss on a timeout; a repeated timeout reports again
    function automatic logic report_soc_timeout();
        logic fire;
        fire = !soc_loss_flagged || soc_timeout_flagged;
        soc_loss_flagged = 1'b1;
        soc_timeout_flagged = 1'b1;
        return fire;
    endfunction

    function automatic void clear_soc_reports();
        soc_loss_flagged = 1'b0;
        soc_timeout_flagged = 1'b0;
    endfunction

    // Advance the shadow state by one event and return the result it gives
    function automatic dll_result_t next_outcome(input ev_kind_t kind_in,
                                                 input logic [2:0] cls,
                                                 input logic mux0);
        ev_kind_t    ev;
        logic        preop2;
        logic        ready;
        logic        soc;
        logic        soa;
        logic        preq;
        logic        rpreq;
        dll_result_t outcome;

        ev = (kind_in == EV_AINV && !invite_enable) ? EV_OTHER : kind_in;
        ready = (cls == CLS_READY || cls == CLS_OPERATIONAL) && mux0;
        preop2 = (cls == CLS_PREOP2);
        soc = 1'b0;
        soa = 1'b0;
        preq = 1'b0;
        rpreq = 1'b0;

        if (cls == CLS_OFF) begin
            node_state = ST_INIT;
        end
        else if (cls == CLS_PREOP1) begin
            node_state = (ev == EV_SOC) ? ST_WAIT_PREQ : ST_INIT;
        end
        else if (cls == CLS_PREOP2 || cls == CLS_READY || cls == CLS_OPERATIONAL) begin
            // Full-cycle table
            case (node_state)
                ST_INIT:
                begin
                    node_state = ST_WAIT_PREQ;
                end
                ST_WAIT_PREQ:
                begin
                    if (ev == EV_PREQ) begin
                        rpreq = 1'b1;
                        node_state = ST_WAIT_SOA;
                    end
                    else if (ev == EV_TIMEOUT) begin
                        if (!preop2) begin
                            soc = report_soc_timeout();
                            soa = 1'b1;
                            node_state = ST_WAIT_SOC;
                        end
                    end
                    else if (ev == EV_AINV) begin
                        if (ready) begin
                            preq = 1'b1;
                            soa = 1'b1;
                        end
                        node_state = ST_WAIT_SOC;
                    end
                    else if (ev == EV_SOA) begin
                        if (ready)
                            preq = 1'b1;
                        node_state = ST_WAIT_SOC;
                    end
                    else if (ev == EV_SOC || ev == EV_ASND) begin
                        soa = 1'b1;
                    end
                end
                ST_WAIT_SOC:
                begin
                    if (ev == EV_SOC) begin
                        node_state = ST_WAIT_PREQ;
                        clear_soc_reports();
                    end
                    else if (ev == EV_TIMEOUT) begin
                        if (!preop2)
                            soc = report_soc_timeout();
                    end
                    else if (ev == EV_PRES || ev == EV_PREQ) begin
                        node_state = ST_WAIT_SOA;
                        soc = report_soc_loss();
                    end
                    else if (ev == EV_SOA) begin
                        if (preop2)
                            soc = 1'b1;
                        else
                            soc = report_soc_loss();
                    end
                end
                default:
                begin
                    if (ev == EV_TIMEOUT) begin
                        if (!preop2) begin
                            soc = report_soc_timeout();
                            node_state = ST_WAIT_SOC;
                        end
                    end
                    else if (ev == EV_PREQ || ev == EV_SOA) begin
                        if (ev == EV_PREQ) begin
                            soc = report_soc_loss();
                            soa = 1'b1;
                        end
                        node_state = ST_WAIT_SOC;
                        clear_soc_reports();
                    end
                    else if (ev == EV_SOC) begin
                        soa = 1'b1;
                        node_state = ST_WAIT_PREQ;
                    end
                    else if (ev == EV_ASND) begin
                        soa = 1'b1;
                    end
                end
            endcase
        end
        else if (cls == CLS_STOPPED) begin
            // Stopped table; init goes straight to wait SoA
            case (node_state)
                ST_INIT:
                begin
                    node_state = ST_WAIT_SOA;
                end
                ST_WAIT_PREQ:
                begin
                    if (ev == EV_PREQ) begin
                        node_state = ST_WAIT_SOA;
                    end
                    else if (ev == EV_TIMEOUT) begin
                        soc = report_soc_timeout();
                        soa = 1'b1;
                        node_state = ST_WAIT_SOC;
                    end
                    else if (ev == EV_SOA) begin
                        node_state = ST_WAIT_SOC;
                    end
                    else if (ev == EV_SOC || ev == EV_ASND) begin
                        soa = 1'b1;
                    end
                end
                ST_WAIT_SOC:
                begin
                    if (ev == EV_SOC)
                        node_state = ST_WAIT_SOA;
                    else if (ev == EV_PREQ || ev == EV_SOA)
                        soc = report_soc_loss();
                    else if (ev == EV_TIMEOUT)
                        soc = report_soc_timeout();
                end
                default:
                begin
                    if (ev == EV_TIMEOUT) begin
                        soc = report_soc_timeout();
                        soa = 1'b1;
                        node_state = ST_WAIT_SOC;
                    end
                    else if (ev == EV_AINV) begin
                        soa = 1'b1;
                        node_state = ST_WAIT_SOC;
                    end
                    else if (ev == EV_SOA) begin
                        node_state = ST_WAIT_SOC;
                    end
                    else if (ev == EV_SOC || ev == EV_ASND) begin
                        soa = 1'b1;
                    end
                end
            endcase
        end
        // Unknown classes hold the state and raise nothing

        outcome.dll_state = node_state;
        outcome.flags.loss_soc = soc;
        outcome.flags.loss_soa = soa;
        outcome.flags.loss_preq = preq;
        outcome.flags.preq_received = rpreq;
        outcome.flags.error_post = soc | soa | preq | rpreq;
        return outcome;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Compare result beats, then fold in event beats and register writes
    always @(posedge clk or negedge rst_n) begin
        dll_result_t want;
        if (!rst_n) begin
            node_state = ST_INIT;
            soc_loss_flagged = 1'b0;
            soc_timeout_flagged = 1'b0;
            invite_enable = 1'b0;
            pending_outcomes.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else begin
            if (res_valid && !res_stall) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: result beat mismatch: expected none, actual state %0d",
                             $time, dll_state_out);
                    fail_count++;
                end
                else begin
                    want = pending_outcomes.pop_front();
                    check_field("dll_state_out", want.dll_state, dll_state_out);
                    check_field("loss_soc", want.flags.loss_soc, loss_soc);
                    check_field("loss_soa", want.flags.loss_soa, loss_soa);
                    check_field("loss_preq", want.flags.loss_preq, loss_preq);
                    check_field("preq_received", want.flags.preq_received, preq_received);
                    check_field("error_post", want.flags.error_post, error_post);
                end
            end
            if (cfg_wr_en)
                invite_enable = cfg_wr_data;
            if (evt_valid && !evt_stall)
                pending_outcomes.push_back(next_outcome(ev_kind_t'(kind), nmt_class,
                                                        mux_cycle_zero));
            pending_count = pending_outcomes.size();
        end
    end

endmodule

FILE: tb/cyclic_node_dll_state_machine_unit_tb.sv
// ----------------------------------------------------------------------------
// DLL state machine testbench
// Drives directed and protocol-shaped random event beats into the
// controlled-node DLL state machine under both invite settings, with bursty
// input traffic and several result stall styles; a checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cyclic_node_dll_state_machine_unit_tb;
    import cndsm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       evt_valid;
    logic       evt_stall;
    logic [2:0] kind;
    logic [2:0] nmt_class;
    logic       mux_cycle_zero;
    logic       res_valid;
    logic       res_stall;
    logic [1:0] dll_state_out;
    logic       loss_soc;
    logic       loss_soa;
    logic       loss_preq;
    logic       preq_received;
    logic       error_post;

    int         fail_count;
    int         pending_count;
    int         cycle_count;
    int         beats_sent;
    int         directed_beats;
    int         burst_left;
    logic       gaps_on;
    logic [2:0] bus_class;
    rx_mode_t   rx_mode;
    logic       hold_toggle;
    logic       hold_ack;

    cyclic_node_dll_state_machine_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .evt_valid      (evt_valid),
        .evt_stall      (evt_stall),
        .kind           (kind),
        .nmt_class      (nmt_class),
        .mux_cycle_zero (mux_cycle_zero),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .dll_state_out  (dll_state_out),
        .loss_soc       (loss_soc),
        .loss_soa       (loss_soa),
        .loss_preq      (loss_preq),
        .preq_received  (preq_received),
        .error_post     (error_post)
    );

    cyclic_node_dll_state_machine_unit_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .evt_valid      (evt_valid),
        .evt_stall      (evt_stall),
        .kind           (kind),
        .nmt_class      (nmt_class),
        .mux_cycle_zero (mux_cycle_zero),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .dll_state_out  (dll_state_out),
        .loss_soc       (loss_soc),
        .loss_soa       (loss_soa),
        .loss_preq      (loss_preq),
        .preq_received  (preq_received),
        .error_post     (error_post),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Offer one event beat and hold it until accepted
    task automatic send_beat(input ev_kind_t ev, input logic [2:0] cls, input logic mux0);
        @(negedge clk);
        evt_valid = 1'b1;
        kind = ev;
        nmt_class = cls;
        mux_cycle_zero = mux0;
        @(posedge clk);
        while (evt_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // Drop valid with junk on the payload
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge clk);
            evt_valid = 1'b0;
            kind = 3'($urandom);
            nmt_class = 3'($urandom);
            mux_cycle_zero = 1'($urandom);
            @(posedge clk);
        end
    endtask

    // Stop offering and wait until every result beat has come back
    task automatic drain();
        @(negedge clk);
        evt_valid = 1'b0;
        wait (pending_count == 0);
        @(negedge clk);
    endtask

    task automatic write_invite_enable(input logic value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
    endtask

    // Mostly full-cycle and stopped classes, sometimes the others
    function automatic logic [2:0] pick_class();
        if ($urandom_range(0, 4) == 0)
            return 3'($urandom_range(0, 1) ? $urandom_range(6, 7) : $urandom_range(0, 1));
        return 3'($urandom_range(2, 5));
    endfunction

    // Send one frame of a bus cycle, now and then distorted, inside bursts
    task automatic offer(input ev_kind_t ev, input logic mux0);
        int         roll;
        ev_kind_t   sent_kind;
        logic [2:0] cls;
        roll = $urandom_range(0, 99);
        sent_kind = ev;
        cls = bus_class;
        if (roll < 3)
            return;
        if (roll < 11)
            sent_kind = EV_TIMEOUT;
        else if (roll < 15)
            sent_kind = ev_kind_t'($urandom_range(0, 7));
        else if (roll < 18)
            cls = 3'($urandom);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on)
                idle_cycles($urandom_range(0, 6));
        end
        burst_left--;
        send_beat(sent_kind, cls, mux0);
    endtask

    // Emit one bus cycle: SoC, usually PReq, PRes frames, SoA and an async frame
    task automatic emit_bus_cycle();
        logic mux0;
        int   n_pres;
        if ($urandom_range(0, 9) == 0)
            bus_class = pick_class();
        mux0 = ($urandom_range(0, 2) == 0);
        n_pres = $urandom_range(0, 2);
        offer(EV_SOC, mux0);
        if ($urandom_range(0, 4) != 0)
            offer(EV_PREQ, mux0);
        repeat (n_pres)
            offer(EV_PRES, mux0);
        offer(EV_SOA, mux0);
        if ($urandom_range(0, 1) == 0)
            offer(EV_ASND, mux0);
        else
            offer(EV_AINV, mux0);
    endtask

    task automatic run_random(input int count, input int hold_at);
        int stop_at;
        int hold_mark;
        stop_at = beats_sent + count;
        hold_mark = beats_sent + hold_at;
        while (beats_sent < stop_at) begin
            if (hold_at > 0 && beats_sent >= hold_mark) begin
                hold_toggle = ~hold_toggle;
                hold_at = 0;
            end
            emit_bus_cycle();
        end
    endtask

    // Result side: stall per mode, or hold off for a long stretch on request
    initial begin
        int hold_left;
        int pattern_cnt;
        hold_left = 0;
        pattern_cnt = 0;
        hold_ack = 1'b0;
        res_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_toggle != hold_ack) begin
                hold_ack = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_stall = 1'b1;
                hold_left--;
            end
            else begin
                case (rx_mode)
                    RX_RANDOM:  res_stall = ($urandom_range(0, 99) < 40);
                    RX_PATTERN: res_stall = ((pattern_cnt % 7) >= 4);
                    default:    res_stall = 1'b0;
                endcase
                pattern_cnt++;
            end
        end
    end

    // Bound the run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        evt_valid = 1'b0;
        kind = EV_OTHER;
        nmt_class = CLS_OFF;
        mux_cycle_zero = 1'b0;
        beats_sent = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        bus_class = CLS_READY;
        rx_mode = RX_RANDOM;
        hold_toggle = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed walk with invites disabled
        write_invite_enable(1'b0);
        send_beat(EV_SOC, CLS_OFF, 1'b0);
        send_beat(EV_SOC, CLS_PREOP1, 1'b0);
        send_beat(EV_OTHER, CLS_OTHER, 1'b1);
        send_beat(EV_PRES, CLS_RESERVED, 1'b0);
        send_beat(EV_ASND, CLS_PREOP1, 1'b1);
        send_beat(EV_SOC, CLS_OPERATIONAL, 1'b1);
        send_beat(EV_PREQ, CLS_OPERATIONAL, 1'b1);
        send_beat(EV_ASND, CLS_OPERATIONAL, 1'b1);
        send_beat(EV_SOA, CLS_OPERATIONAL, 1'b1);
        send_beat(EV_SOC, CLS_OPERATIONAL, 1'b1);
        send_beat(EV_SOA, CLS_READY, 1'b1);
        send_beat(EV_SOC, CLS_READY, 1'b0);
        send_beat(EV_TIMEOUT, CLS_READY, 1'b0);
        send_beat(EV_TIMEOUT, CLS_READY, 1'b0);
        send_beat(EV_TIMEOUT, CLS_PREOP2, 1'b0);
        send_beat(EV_PREQ, CLS_PREOP2, 1'b0);
        send_beat(EV_SOA, CLS_PREOP2, 1'b0);
        send_beat(EV_AINV, CLS_OPERATIONAL, 1'b1);
        send_beat(EV_OTHER, CLS_OFF, 1'b1);
        send_beat(EV_OTHER, CLS_STOPPED, 1'b0);
        send_beat(EV_AINV, CLS_STOPPED, 1'b0);
        send_beat(EV_SOC, CLS_PREOP1, 1'b0);
        send_beat(EV_PREQ, CLS_STOPPED, 1'b0);
        drain();

        // Directed invite paths with invites enabled
        write_invite_enable(1'b1);
        send_beat(EV_SOC, CLS_OFF, 1'b0);
        send_beat(EV_SOC, CLS_READY, 1'b1);
        send_beat(EV_AINV, CLS_READY, 1'b1);
        send_beat(EV_SOC, CLS_STOPPED, 1'b0);
        send_beat(EV_AINV, CLS_STOPPED, 1'b0);
        directed_beats = beats_sent;

        // Random bus cycles, random result stalls, one long result hold
        run_random(200, 90);
        drain();

        // Invites off, patterned stalls, pause for a full drain midway
        write_invite_enable(1'b0);
        rx_mode = RX_PATTERN;
        run_random(100, 0);
        drain();
        run_random(100, 0);
        drain();

        // Invites on, no idling on either side
        write_invite_enable(1'b1);
        rx_mode = RX_FREE;
        gaps_on = 1'b0;
        run_random(150, 0);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d event beats (%0d directed) over both invite settings,",
                 beats_sent, directed_beats);
        $display("with free, random and patterned result stalls and a long result hold.");
        if (fail_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
